>>> rtl/hes_pkg.sv
// ----------------------------------------------------------------------------
// hes_pkg: shared types and constants
// Word layouts, opcodes, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package hes_pkg;

    localparam int BINS = 256;

    // opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;
    localparam logic [1:0] OP_MAP   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PIXEL_COUNT      = 3'd0;
    localparam logic [2:0] CFG_LOW_PERCENT      = 3'd1;
    localparam logic [2:0] CFG_HIGH_PERCENT     = 3'd2;
    localparam logic [2:0] CFG_TARGET_FIRST_BIN = 3'd3;
    localparam logic [2:0] CFG_TARGET_BIN_COUNT = 3'd4;

    // divider operand select
    localparam logic [1:0] DIV_EQ  = 2'd0;
    localparam logic [1:0] DIV_INV = 2'd1;
    localparam logic [1:0] DIV_STR = 2'd2;

    localparam logic [20:0] BIN_MAX   = 21'h1FFFFF;
    localparam logic [7:0]  TOP_VALUE = 8'd255;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0] equalized_value;
        logic [7:0] specified_value;
        logic [7:0] stretched_value;
        logic [7:0] low_point;
        logic [7:0] high_point;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [20:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic       latch_in;
        logic       hist_clr;
        logic       hist_rd_px;
        logic       hist_rd_bin;
        logic       hist_wr;
        logic       build_init;
        logic       acc_upd;
        logic       cum_upd;
        logic       div_start;
        logic [1:0] div_sel;
        logic       eq_wr;
        logic       inv_first;
        logic       inv_take;
        logic       fill_step;
        logic       bin_next;
        logic       spec_last;
        logic       map_rd;
        logic       map_sprd;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic bin_zero;
        logic bin_last;
        logic fill_done;
    } t_sts;

endpackage

>>> rtl/hes_chan_if.sv
// ----------------------------------------------------------------------------
// hes_chan_if: valid/ready channel
// Carries one word of type T from source to sink.
// ----------------------------------------------------------------------------
interface hes_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/hes_div.sv
// ----------------------------------------------------------------------------
// hes_div: restoring divider, quotient clamped to 256
// One saturation check, then one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hes_div
    import hes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_x,
    input  logic [22:0] i_d2,
    output logic        o_busy,
    output logic [8:0]  o_quot
);
    logic        r_busy;
    logic [3:0]  r_k;
    logic [39:0] r_rem;
    logic [30:0] r_sh;
    logic [8:0]  r_q;
    logic        w_ge;

    assign w_ge = r_rem >= 40'(r_sh);

    // iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_rem  <= i_x;
            r_sh   <= {i_d2, 8'd0};
            r_k    <= 4'd8;
            r_q    <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_k == 4'd8) begin
                // quotient of 256 or more clamps
                if (w_ge) begin
                    r_q    <= 9'd256;
                    r_busy <= 1'b0;
                end else begin
                    r_k  <= 4'd7;
                    r_sh <= r_sh >> 1;
                end
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - 40'(r_sh);
                    r_q   <= r_q | (9'd1 << r_k);
                end
                if (r_k == 4'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k  <= r_k - 4'd1;
                    r_sh <= r_sh >> 1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

>>> rtl/hes_dp.sv
// ----------------------------------------------------------------------------
// hes_dp: datapath
// Histogram, equalize and specify tables, build walk registers, config
// registers, shared divider and the output register.
// ----------------------------------------------------------------------------
module hes_dp
    import hes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  logic      i_cfg_wr,
    input  t_cfg_word i_cfg,
    input  t_in_word  i_word,
    output t_out_word o_word
);
    // config registers
    logic [20:0] r_pixel_count;
    logic [6:0]  r_low_percent;
    logic [6:0]  r_high_percent;
    logic [7:0]  r_first;
    logic [15:0] r_tbc;

    logic [7:0]  r_px;

    logic [20:0] r_hist [BINS];
    logic [BINS-1:0] r_hvld;
    logic [20:0] r_hrd;

    logic [7:0]  r_eqm [BINS];
    logic [7:0]  r_eqrd;

    logic [7:0]  r_spm [BINS];
    logic [BINS-1:0] r_spvld;
    logic [7:0]  r_sprd;

    logic [7:0]  r_bin;
    logic [28:0] r_acc;
    logic [23:0] r_s;
    logic [27:0] r_lothr;
    logic [27:0] r_hithr;
    logic        r_hneg;
    logic [35:0] r_cum100;
    logic [7:0]  r_low;
    logic [7:0]  r_high;
    logic        r_hfound;
    logic [8:0]  r_prev;
    logic [8:0]  r_cur;
    logic [8:0]  r_j;
    t_out_word   r_out;

    logic [20:0] w_n;
    logic [39:0] w_x;
    logic [22:0] w_d2;
    logic [39:0] w_acc40;
    logic [39:0] w_s40;
    logic [7:0]  w_sd;
    logic [7:0]  w_sr;
    logic        w_busy;
    logic [8:0]  w_q;
    logic [7:0]  w_hist_addr;
    logic        w_same;
    logic        w_jin;
    logic        w_sp_we;
    logic [7:0]  w_sp_addr;
    logic [7:0]  w_sp_data;
    logic [7:0]  w_st;

    // zero image size counts as one
    assign w_n = (r_pixel_count == 21'd0) ? 21'd1 : r_pixel_count;

    // divider operands: x = 510*v + d, divisor 2*d
    assign w_acc40 = 40'(r_acc);
    assign w_s40   = 40'(r_s);
    assign w_sd    = r_high - r_low;
    assign w_sr    = r_px - r_low;
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_EQ: begin
                w_x  = (w_acc40 << 9) - (w_acc40 << 1) + 40'(w_n);
                w_d2 = {1'b0, w_n, 1'b0};
            end
            DIV_INV: begin
                w_x  = (w_s40 << 9) - (w_s40 << 1) + 40'(w_n);
                w_d2 = {1'b0, w_n, 1'b0};
            end
            DIV_STR: begin
                w_x  = (40'(w_sr) << 9) - (40'(w_sr) << 1) + 40'(w_sd);
                w_d2 = {14'd0, w_sd, 1'b0};
            end
            default: begin
                w_x  = '0;
                w_d2 = '0;
            end
        endcase
    end

    hes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_x     (w_x),
        .i_d2    (w_d2),
        .o_busy  (w_busy),
        .o_quot  (w_q)
    );

    // config and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count  <= 21'd262144;
            r_low_percent  <= 7'd10;
            r_high_percent <= 7'd30;
            r_first        <= 8'd128;
            r_tbc          <= 16'd2048;
            r_low          <= 8'd0;
            r_high         <= TOP_VALUE;
            r_hvld         <= '0;
            r_spvld        <= '0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg.index)
                    CFG_PIXEL_COUNT:      r_pixel_count  <= i_cfg.value;
                    CFG_LOW_PERCENT:      r_low_percent  <= i_cfg.value[6:0];
                    CFG_HIGH_PERCENT:     r_high_percent <= i_cfg.value[6:0];
                    CFG_TARGET_FIRST_BIN: r_first        <= i_cfg.value[7:0];
                    CFG_TARGET_BIN_COUNT: r_tbc          <= i_cfg.value[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.hist_clr) r_hvld <= '0;
            if (i_cmd.hist_wr)  r_hvld[r_px] <= 1'b1;
            if (i_cmd.build_init) begin
                r_spvld <= '0;
                r_low   <= 8'd0;
                r_high  <= TOP_VALUE;
            end
            if (w_sp_we) r_spvld[w_sp_addr] <= 1'b1;
            // stretch points from the running cumulative sum
            if (i_cmd.eq_wr) begin
                if (r_cum100 < 36'(r_lothr)) r_low <= r_bin;
                if (!r_hfound && (r_hneg || r_cum100 > 36'(r_hithr))) r_high <= r_bin;
            end
        end
    end

    // histogram memory
    assign w_hist_addr = i_cmd.hist_rd_bin ? r_bin : r_px;
    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_rd_px || i_cmd.hist_rd_bin) begin
            r_hrd <= r_hvld[w_hist_addr] ? r_hist[w_hist_addr] : 21'd0;
        end
        if (i_cmd.hist_wr) begin
            r_hist[r_px] <= (r_hrd == BIN_MAX) ? r_hrd : r_hrd + 21'd1;
        end
    end

    // equalize table
    always_ff @(posedge i_clk) begin
        if (i_cmd.eq_wr) r_eqm[r_bin] <= w_q[8] ? TOP_VALUE : w_q[7:0];
        if (i_cmd.map_rd) r_eqrd <= r_eqm[r_px];
    end

    // specify table fill: a run of entries, a single zero on a flat step, or the top entry at the end
    assign w_same = r_prev == r_cur;
    assign w_jin  = (r_j < r_cur) && !r_j[8];
    always_comb begin
        w_sp_we   = 1'b0;
        w_sp_addr = r_j[7:0];
        w_sp_data = r_bin;
        if (i_cmd.spec_last) begin
            w_sp_we   = 1'b1;
            w_sp_addr = TOP_VALUE;
            w_sp_data = TOP_VALUE;
        end else if (i_cmd.fill_step) begin
            if (w_same) begin
                w_sp_we   = !r_prev[8];
                w_sp_addr = r_prev[7:0];
                w_sp_data = 8'd0;
            end else begin
                w_sp_we = w_jin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sp_we) r_spm[w_sp_addr] <= w_sp_data;
        if (i_cmd.map_sprd) r_sprd <= r_spvld[r_eqrd] ? r_spm[r_eqrd] : 8'd0;
    end

    // build walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) r_px <= i_word.pixel;
        if (i_cmd.build_init) begin
            r_acc    <= '0;
            r_s      <= '0;
            r_bin    <= '0;
            r_hfound <= 1'b0;
            r_lothr  <= 28'(28'(w_n) * 28'(r_low_percent));
            r_hithr  <= 28'(28'(w_n) * 28'(7'd100 - r_high_percent));
            r_hneg   <= r_high_percent > 7'd100;
        end
        if (i_cmd.acc_upd) begin
            r_acc <= r_acc + 29'(r_hrd);
            if (r_bin >= r_first) r_s <= r_s + 24'(r_tbc);
        end
        if (i_cmd.cum_upd) begin
            r_cum100 <= (36'(r_acc) << 6) + (36'(r_acc) << 5) + (36'(r_acc) << 2);
        end
        if (i_cmd.eq_wr && !r_hfound && (r_hneg || r_cum100 > 36'(r_hithr))) begin
            r_hfound <= 1'b1;
        end
        if (i_cmd.inv_first) begin
            r_prev <= w_q;
            r_bin  <= r_bin + 8'd1;
        end
        if (i_cmd.inv_take) begin
            r_cur <= w_q;
            r_j   <= r_prev;
        end
        if (i_cmd.fill_step && !w_same && w_jin) r_j <= r_j + 9'd1;
        if (i_cmd.bin_next) begin
            r_prev <= r_cur;
            r_bin  <= r_bin + 8'd1;
        end
    end

    // stretch value
    always_comb begin
        if (r_px <= r_low)       w_st = 8'd0;
        else if (r_px >= r_high) w_st = TOP_VALUE;
        else                     w_st = w_q[7:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.equalized_value <= r_eqrd;
            r_out.specified_value <= r_sprd;
            r_out.stretched_value <= w_st;
            r_out.low_point       <= r_low;
            r_out.high_point      <= r_high;
        end
    end

    assign o_word          = r_out;
    assign o_sts.div_busy  = w_busy;
    assign o_sts.bin_zero  = r_bin == 8'd0;
    assign o_sts.bin_last  = r_bin == TOP_VALUE;
    assign o_sts.fill_done = w_same || !w_jin;
endmodule

>>> rtl/hes_ctrl.sv
// ----------------------------------------------------------------------------
// hes_ctrl: sequencer
// Steps each opcode through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module hes_ctrl
    import hes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CWR   = 4'd3;
    localparam logic [3:0] S_BINIT = 4'd4;
    localparam logic [3:0] S_BRD   = 4'd5;
    localparam logic [3:0] S_BACC  = 4'd6;
    localparam logic [3:0] S_BMUL  = 4'd7;
    localparam logic [3:0] S_BDEQ  = 4'd8;
    localparam logic [3:0] S_BDINV = 4'd9;
    localparam logic [3:0] S_BFILL = 4'd10;
    localparam logic [3:0] S_BEND  = 4'd11;
    localparam logic [3:0] S_MRD   = 4'd12;
    localparam logic [3:0] S_MSP   = 4'd13;
    localparam logic [3:0] S_MOUT  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;
    logic       w_out_free;

    assign o_in_ready = r_state == S_IDLE;
    assign w_out_free = !r_ovalid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    unique case (i_in_op)
                        OP_CLEAR: n_state = S_CLR;
                        OP_COUNT: n_state = S_CRD;
                        OP_BUILD: n_state = S_BINIT;
                        OP_MAP:   n_state = S_MRD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.hist_clr = 1'b1;
                n_state = S_IDLE;
            end
            S_CRD: begin
                o_cmd.hist_rd_px = 1'b1;
                n_state = S_CWR;
            end
            S_CWR: begin
                o_cmd.hist_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_BINIT: begin
                o_cmd.build_init = 1'b1;
                n_state = S_BRD;
            end
            S_BRD: begin
                o_cmd.hist_rd_bin = 1'b1;
                n_state = S_BACC;
            end
            S_BACC: begin
                o_cmd.acc_upd = 1'b1;
                n_state = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.cum_upd   = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_EQ;
                n_state = S_BDEQ;
            end
            S_BDEQ: begin
                if (!i_sts.div_busy) begin
                    o_cmd.eq_wr     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_INV;
                    n_state = S_BDINV;
                end
            end
            S_BDINV: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.bin_zero) begin
                        o_cmd.inv_first = 1'b1;
                        n_state = S_BRD;
                    end else begin
                        o_cmd.inv_take = 1'b1;
                        n_state = S_BFILL;
                    end
                end
            end
            S_BFILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_done) begin
                    o_cmd.bin_next = 1'b1;
                    n_state = i_sts.bin_last ? S_BEND : S_BRD;
                end
            end
            S_BEND: begin
                o_cmd.spec_last = 1'b1;
                n_state = S_IDLE;
            end
            S_MRD: begin
                o_cmd.map_rd    = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STR;
                n_state = S_MSP;
            end
            S_MSP: begin
                o_cmd.map_sprd = 1'b1;
                n_state = S_MOUT;
            end
            S_MOUT: begin
                if (!i_sts.div_busy && w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)   r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule

>>> rtl/histogram_equalize_specify_stretch.sv
// ----------------------------------------------------------------------------
// histogram_equalize_specify_stretch: 8-bit equalize / specify / stretch
//
//   channel  dir  word          accepted when
//   i_in     in   t_in_word     i_in.valid & i_in.ready
//   o_out    out  t_out_word    o_out.valid & o_out.ready (map only)
//   i_cfg    in   t_cfg_word    i_cfg.valid (ready always high)
//
// Map runs the stretch divide in the shared divider before loading the output.
// Build walks 256 bins; each bin takes two divides in the shared divider
// plus fill steps that write its specify entries.
// Input is taken only between items; a waiting output word does not block
// clear, count or build. Reset is synchronous and clears the histogram and
// specify table valid bits.
// ----------------------------------------------------------------------------
module histogram_equalize_specify_stretch
    import hes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    hes_chan_if.sink   i_in,
    hes_chan_if.source o_out,
    hes_chan_if.sink   i_cfg
);
    t_cmd      w_cmd;
    t_sts      w_sts;
    t_in_word  w_in;
    t_cfg_word w_cfg;
    t_out_word w_out;

    assign w_in        = i_in.data;
    assign w_cfg       = i_cfg.data;
    assign i_cfg.ready = 1'b1;
    assign o_out.data  = w_out;

    hes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (w_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hes_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_cfg_wr (i_cfg.valid),
        .i_cfg    (w_cfg),
        .i_word   (w_in),
        .o_word   (w_out)
    );
endmodule

>>> rtl/hes_check.sv
// ----------------------------------------------------------------------------
// hes_check: port-level checks
// Reset, output stall hold and one-item-at-a-time behavior.
// ----------------------------------------------------------------------------
module hes_check
    import hes_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);
    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output word changed under stall");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on back-to-back cycles");

    // no result in the cycle right after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result too soon after accept");
endmodule

bind histogram_equalize_specify_stretch hes_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
